### rtl/pcpf_pkg.sv
// Shared constants, command/status structs for the polyline point filter.
// No dependencies; compiled first.
package pcpf_pkg;

  // Coordinate width used when the top level is not overridden
  localparam int COORD_BITS_DEF = 16;

  // Threshold register: signed Q1.15
  localparam int CTH_BITS  = 16;
  localparam int CM_BITS   = 16;
  localparam int FRAC_BITS = 15;
  localparam logic signed [CTH_BITS-1:0] COS_RESET = 16'sd32767;

  // APB port
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;
  localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;
  localparam logic [REG_IDX_BITS-1:0] IDX_COS_THRESHOLD = 1'b0;

  // Last count value of both the operand pipeline fill and the product sweep
  localparam logic [1:0] CNT_LAST = 2'd3;

  typedef struct packed {
    logic       load_cur;   // capture the accepted point
    logic       mac_en;     // run one partial-product step
    logic [1:0] mac_sel;    // {a limb, b limb} of this step
    logic       load_mid;   // load the held middle point into the output word
    logic       load_last;  // load the current point into the output word
    logic       shift;      // advance the point history
  } pcpf_cmd_t;

  typedef struct packed {
    logic cur_last;
    logic turn;
    logic out_free;
  } pcpf_sts_t;

endpackage

### rtl/pcpf_if.sv
// Valid/ready channel interfaces for incoming points and kept points.
// Depends on pcpf_pkg for the default coordinate width.
interface pcpf_point_if #(parameter int COORD_BITS = pcpf_pkg::COORD_BITS_DEF) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         end_of_curve;

  modport source (output valid, point_x, point_y, point_z, end_of_curve, input ready);
  modport sink (input valid, point_x, point_y, point_z, end_of_curve, output ready);
endinterface

interface pcpf_kept_if #(parameter int COORD_BITS = pcpf_pkg::COORD_BITS_DEF) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] kept_x;
  logic signed [COORD_BITS-1:0] kept_y;
  logic signed [COORD_BITS-1:0] kept_z;
  logic                         curve_done;

  modport source (output valid, kept_x, kept_y, kept_z, curve_done, input ready);
  modport sink (input valid, kept_x, kept_y, kept_z, curve_done, output ready);
endinterface

### rtl/pcpf_regs.sv
// APB register bank holding the cosine threshold.
// Depends on pcpf_pkg for address decode and reset value.
module pcpf_regs (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [pcpf_pkg::APB_ADDR_BITS-1:0]        paddr,
  input  logic [pcpf_pkg::APB_DATA_BITS-1:0]        pwdata,
  output logic [pcpf_pkg::APB_DATA_BITS-1:0]        prdata,
  output logic                                      pready,
  output logic signed [pcpf_pkg::CTH_BITS-1:0]      cos_threshold
);
  import pcpf_pkg::*;

  logic [REG_IDX_BITS-1:0] idx;
  logic                    wr_en;

  assign idx    = paddr[APB_ADDR_BITS-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_threshold <= COS_RESET;
    end else if (wr_en && (idx == IDX_COS_THRESHOLD)) begin
      cos_threshold <= pwdata[CTH_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx == IDX_COS_THRESHOLD) begin
      prdata[CTH_BITS-1:0] = cos_threshold;
    end
  end

endmodule

### rtl/pcpf_ctrl.sv
// Sequencer: accepts one point, steps the datapath through the turn test
// and the output loads, then advances the point history. Uses pcpf_pkg.
module pcpf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pcpf_pkg::pcpf_sts_t  sts,
  output pcpf_pkg::pcpf_cmd_t  cmd
);
  import pcpf_pkg::*;

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MAC,
    ST_CMP,
    ST_DECIDE,
    ST_EMIT_MID,
    ST_EMIT_CUR,
    ST_COMMIT
  } state_t;

  state_t     state;
  logic [1:0] cnt;
  logic [1:0] seen;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load_cur  = in_valid && in_ready;
    cmd.mac_en    = (state == ST_MAC);
    cmd.mac_sel   = cnt;
    cmd.load_mid  = (state == ST_EMIT_MID) && sts.out_free;
    cmd.load_last = (state == ST_EMIT_CUR) && sts.out_free;
    cmd.shift     = (state == ST_COMMIT) && !sts.cur_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      seen  <= SEEN_NONE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cnt   <= '0;
            // two points held: run the turn test first
            state <= (seen >= SEEN_TWO) ? ST_CALC : ST_DECIDE;
          end
        end
        ST_CALC: begin
          cnt <= cnt + 2'd1;
          if (cnt == CNT_LAST) begin
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          cnt <= cnt + 2'd1;
          if (cnt == CNT_LAST) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if ((seen >= SEEN_TWO) && sts.turn) begin
            state <= ST_EMIT_MID;
          end else if ((seen == SEEN_NONE) || sts.cur_last) begin
            state <= ST_EMIT_CUR;
          end else begin
            state <= ST_COMMIT;
          end
        end
        ST_EMIT_MID: begin
          if (sts.out_free) begin
            state <= sts.cur_last ? ST_EMIT_CUR : ST_COMMIT;
          end
        end
        ST_EMIT_CUR: begin
          if (sts.out_free) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (sts.cur_last) begin
            seen <= SEEN_NONE;
          end else begin
            seen <= (seen == SEEN_NONE) ? SEEN_ONE : SEEN_TWO;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/pcpf_dp.sv
// Datapath: point history, difference/product/sum pipeline, limb-wise wide
// products, exact turn compare and the output word register. Uses pcpf_pkg.
module pcpf_dp #(
  parameter int COORD_BITS = pcpf_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [COORD_BITS-1:0]          pt_x,
  input  logic signed [COORD_BITS-1:0]          pt_y,
  input  logic signed [COORD_BITS-1:0]          pt_z,
  input  logic                                  pt_last,
  input  logic signed [pcpf_pkg::CTH_BITS-1:0]  cos_threshold,
  input  pcpf_pkg::pcpf_cmd_t                   cmd,
  output pcpf_pkg::pcpf_sts_t                   sts,
  pcpf_kept_if.source                           kept
);
  import pcpf_pkg::*;

  localparam int DW   = COORD_BITS + 1;      // segment component
  localparam int PW   = 2 * DW;              // component product
  localparam int NW   = 2 * COORD_BITS + 2;  // squared length, |dot|
  localparam int SUMW = PW + 2;
  localparam int SW   = NW + CM_BITS;        // scaled operand
  localparam int HW   = (SW + 1) / 2;        // limb
  localparam int AW   = 4 * HW;              // wide product

  localparam logic [1:0] SEL_LO_LO = 2'd0;
  localparam logic [1:0] SEL_LO_HI = 2'd1;
  localparam logic [1:0] SEL_HI_LO = 2'd2;

  // point history
  logic signed [COORD_BITS-1:0] cur  [3];
  logic signed [COORD_BITS-1:0] prev [3];
  logic signed [COORD_BITS-1:0] pbp  [3];
  logic                         cur_last;

  // pipeline
  logic signed [DW-1:0]   u   [3];
  logic signed [DW-1:0]   v   [3];
  logic signed [PW-1:0]   puu [3];
  logic signed [PW-1:0]   pvv [3];
  logic signed [PW-1:0]   puv [3];
  logic signed [SUMW-1:0] n1_sum, n2_sum, dot_sum, dot_mag;
  logic [NW-1:0]          n1, n2, dm;
  logic                   dot_neg, nz;
  logic                   cth_neg;
  logic [CM_BITS-1:0]     cm;
  logic [SW-1:0]          s1, s2, dsh;

  // limb products
  logic [HW-1:0]   ax, bx, ay, by;
  logic [2*HW-1:0] prod_x, prod_y;
  logic [AW-1:0]   term_x, term_y;
  logic [AW-1:0]   acc_x, acc_y;
  logic            turn;

  // output word
  logic out_valid;

  always_ff @(posedge clk) begin
    if (cmd.load_cur) begin
      cur[0]   <= pt_x;
      cur[1]   <= pt_y;
      cur[2]   <= pt_z;
      cur_last <= pt_last;
    end
    if (cmd.shift) begin
      for (int i = 0; i < 3; i++) begin
        pbp[i]  <= prev[i];
        prev[i] <= cur[i];
      end
    end
  end

  // free-running stages; operands hold still while a test runs
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u[i]   <= DW'(prev[i]) - DW'(pbp[i]);
      v[i]   <= DW'(cur[i]) - DW'(prev[i]);
      puu[i] <= PW'(u[i]) * PW'(u[i]);
      pvv[i] <= PW'(v[i]) * PW'(v[i]);
      puv[i] <= PW'(u[i]) * PW'(v[i]);
    end
  end

  always_comb begin
    n1_sum  = SUMW'(puu[0]) + SUMW'(puu[1]) + SUMW'(puu[2]);
    n2_sum  = SUMW'(pvv[0]) + SUMW'(pvv[1]) + SUMW'(pvv[2]);
    dot_sum = SUMW'(puv[0]) + SUMW'(puv[1]) + SUMW'(puv[2]);
    dot_mag = dot_sum[SUMW-1] ? -dot_sum : dot_sum;
    cth_neg = cos_threshold[CTH_BITS-1];
    cm      = cth_neg ? CM_BITS'(-cos_threshold) : CM_BITS'(cos_threshold);
  end

  always_ff @(posedge clk) begin
    n1      <= n1_sum[NW-1:0];
    n2      <= n2_sum[NW-1:0];
    dm      <= dot_mag[NW-1:0];
    dot_neg <= dot_sum[SUMW-1];
    nz      <= (n1_sum != '0) && (n2_sum != '0);
    // compare (dm * 2^15)^2 against (cm * n1) * (cm * n2)
    s1      <= SW'(cm) * SW'(n1);
    s2      <= SW'(cm) * SW'(n2);
    dsh     <= SW'({dm, {FRAC_BITS{1'b0}}});
  end

  always_comb begin
    ax     = cmd.mac_sel[1] ? HW'(dsh[SW-1:HW]) : dsh[HW-1:0];
    bx     = cmd.mac_sel[0] ? HW'(dsh[SW-1:HW]) : dsh[HW-1:0];
    ay     = cmd.mac_sel[1] ? HW'(s1[SW-1:HW]) : s1[HW-1:0];
    by     = cmd.mac_sel[0] ? HW'(s2[SW-1:HW]) : s2[HW-1:0];
    prod_x = (2 * HW)'(ax) * (2 * HW)'(bx);
    prod_y = (2 * HW)'(ay) * (2 * HW)'(by);
    case (cmd.mac_sel)
      SEL_LO_HI, SEL_HI_LO: begin
        term_x = AW'(prod_x) << HW;
        term_y = AW'(prod_y) << HW;
      end
      SEL_LO_LO: begin
        term_x = AW'(prod_x);
        term_y = AW'(prod_y);
      end
      default: begin
        term_x = AW'(prod_x) << (2 * HW);
        term_y = AW'(prod_y) << (2 * HW);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      acc_x <= (cmd.mac_sel == SEL_LO_LO) ? term_x : acc_x + term_x;
      acc_y <= (cmd.mac_sel == SEL_LO_LO) ? term_y : acc_y + term_y;
    end
    // sign-aware decision of dot < c * |u| * |v|
    turn <= nz && (cth_neg ? (dot_neg && (acc_x > acc_y))
                           : (dot_neg || (acc_x < acc_y)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_mid || cmd.load_last) begin
      out_valid <= 1'b1;
    end else if (kept.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mid) begin
      kept.kept_x     <= prev[0];
      kept.kept_y     <= prev[1];
      kept.kept_z     <= prev[2];
      kept.curve_done <= 1'b0;
    end else if (cmd.load_last) begin
      kept.kept_x     <= cur[0];
      kept.kept_y     <= cur[1];
      kept.kept_z     <= cur[2];
      kept.curve_done <= cur_last;
    end
  end

  assign kept.valid   = out_valid;
  assign sts.out_free = !out_valid || kept.ready;
  assign sts.cur_last = cur_last;
  assign sts.turn     = turn;

endmodule

### rtl/polyline_collinear_point_filter_unit.sv
// Top level of the polyline turn-angle point filter.
// Depends on pcpf_pkg, pcpf_if, pcpf_regs, pcpf_ctrl and pcpf_dp.
//
//   channel   direction  handshake        word
//   points    in         valid/ready      point_x, point_y, point_z, end_of_curve
//   kept      out        valid/ready      kept_x, kept_y, kept_z, curve_done
//   apb       in/out     psel/penable     cos_threshold at byte 0
//
// One point at a time. A point with fewer than two earlier points of its curve
// goes from accept straight to the decision; a middle-point test first runs
// four operand stages, four limb steps of the two wide multipliers, a compare
// and the decision. Each word sent passes through an emit state. Sync reset
// clears the sequencer and the output valid flag and sets cos_threshold to 32767.
// A stalled kept channel holds the sequencer in its emit state and points.ready low.
module polyline_collinear_point_filter_unit #(
  parameter int COORD_BITS = pcpf_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  pcpf_point_if.sink                          points,
  pcpf_kept_if.source                         kept,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcpf_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [pcpf_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [pcpf_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import pcpf_pkg::*;

  logic signed [CTH_BITS-1:0] cos_threshold;
  logic                       in_ready;
  pcpf_cmd_t                  cmd;
  pcpf_sts_t                  sts;

  pcpf_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .cos_threshold (cos_threshold)
  );

  pcpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (points.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcpf_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .pt_x          (points.point_x),
    .pt_y          (points.point_y),
    .pt_z          (points.point_z),
    .pt_last       (points.end_of_curve),
    .cos_threshold (cos_threshold),
    .cmd           (cmd),
    .sts           (sts),
    .kept          (kept)
  );

  assign points.ready = in_ready;

  // never overwrite a word that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_mid || cmd.load_last) |-> sts.out_free)
    else $error("output word loaded while occupied");

  // a kept middle point never closes its curve
  a_mid_not_done: assert property (@(posedge clk) disable iff (rst)
    cmd.load_mid |=> (kept.valid && !kept.curve_done))
    else $error("middle point sent with curve_done");

  // no new point while a test or an emit is under way
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    points.ready |-> !(cmd.mac_en || cmd.load_mid || cmd.load_last || cmd.shift))
    else $error("point accepted while busy");

endmodule

### tb/polyline_collinear_point_filter_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the polyline turn-angle point filter: directed and random
// curves, an in-bench keep/drop model, random stalls on both channels, APB threshold writes.
// Depends on pcpf_pkg, the pcpf channel interfaces and polyline_collinear_point_filter_unit.
module polyline_collinear_point_filter_unit_test;
  import pcpf_pkg::*;

  localparam int CB            = COORD_BITS_DEF;
  localparam int MAX_WAIT      = 18;
  localparam int SETTLE_CYCLES = 60;
  localparam int NUM_PHASES    = 7;
  localparam int PHASE_ITEMS   = 130;
  localparam int MAX_PRINTS    = 40;
  localparam longint LIMIT_NS  = 5_000_000;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [CTH_BITS-1:0] cos_t;

  localparam coord_t COORD_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam cos_t   COS_MIN   = {1'b1, {(CTH_BITS-1){1'b0}}};

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct {
    point_t pt;
    logic   last;
    logic   drain_first;  // hold this word until every expected kept point is out
  } point_word_t;

  typedef struct {
    point_t pt;
    logic   done;
  } kept_word_t;

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  pcpf_point_if #(.COORD_BITS(CB)) points ();
  pcpf_kept_if  #(.COORD_BITS(CB)) kept ();

  polyline_collinear_point_filter_unit #(.COORD_BITS(CB)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .points  (points),
    .kept    (kept),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // filter model state
  point_t      prev_pt;
  point_t      older_pt;
  int unsigned pts_in_curve;
  cos_t        cos_thr;

  point_word_t pending_points[$];
  kept_word_t  kept_expected[$];
  int          errors = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [CB-1:0] got, logic [CB-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, $signed(got), $signed(want)));
  endtask

  // Exact test of dot(u,v) < c*|u|*|v| by comparing dot^2 * 2^30 with c^2 * |u|^2 * |v|^2.
  function automatic bit turn_is_sharp(point_t a, point_t b, point_t c, cos_t thr);
    longint ux, uy, uz, vx, vy, vz;
    longint n1, n2, dot, dmag, cmag;
    logic [127:0] dot_sq, lim_sq;
    ux = longint'($signed(b.x)) - longint'($signed(a.x));
    uy = longint'($signed(b.y)) - longint'($signed(a.y));
    uz = longint'($signed(b.z)) - longint'($signed(a.z));
    vx = longint'($signed(c.x)) - longint'($signed(b.x));
    vy = longint'($signed(c.y)) - longint'($signed(b.y));
    vz = longint'($signed(c.z)) - longint'($signed(b.z));
    n1 = ux * ux + uy * uy + uz * uz;
    n2 = vx * vx + vy * vy + vz * vz;
    dot = ux * vx + uy * vy + uz * vz;
    if (n1 == 0 || n2 == 0) return 1'b0;
    dmag = (dot < 0) ? -dot : dot;
    cmag = (thr < 0) ? -longint'(thr) : longint'(thr);
    dot_sq = (128'(dmag) * 128'(dmag)) << (2 * FRAC_BITS);
    lim_sq = 128'(cmag * cmag) * 128'(n1) * 128'(n2);
    if (thr >= 0) return (dot < 0) || (dot_sq < lim_sq);
    return (dot < 0) && (dot_sq > lim_sq);
  endfunction

  // Append one kept point to the expected stream.
  function automatic void expect_kept(point_t pt, logic done);
    kept_word_t w;
    w.pt   = pt;
    w.done = done;
    kept_expected.insert(kept_expected.size(), w);
  endfunction

  // Advance the model by one accepted point and queue the kept points it releases.
  function automatic void filter_point(point_word_t w);
    if (pts_in_curve == 0) begin
      expect_kept(w.pt, w.last);
      if (!w.last) begin
        prev_pt = w.pt;
        pts_in_curve = 1;
      end
    end else begin
      if (pts_in_curve >= 2 && turn_is_sharp(older_pt, prev_pt, w.pt, cos_thr))
        expect_kept(prev_pt, 1'b0);
      if (w.last) begin
        expect_kept(w.pt, 1'b1);
        pts_in_curve = 0;
      end else begin
        older_pt = prev_pt;
        prev_pt = w.pt;
        pts_in_curve = 2;
      end
    end
  endfunction

  function automatic int pick_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 50);
      return 0;
    end
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 3);
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return COORD_MIN;
      1: return COORD_MAX;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t rand_delta(int reach);
    return coord_t'(int'($urandom_range(0, 2 * reach)) - reach);
  endfunction

  // Append one point word to the send queue.
  function automatic void add_pending(point_t pt, logic last, logic drain);
    point_word_t w;
    w.pt          = pt;
    w.last        = last;
    w.drain_first = drain;
    pending_points.insert(pending_points.size(), w);
  endfunction

  function automatic void push_point(int x, int y, int z, bit last);
    add_pending('{coord_t'(x), coord_t'(y), coord_t'(z)}, last, 1'b0);
  endfunction

  // Random walk with repeated, reversed, doubled and zero steps so that straight runs,
  // full reversals and degenerate segments show up often.
  function automatic int queue_curve();
    point_t p, step;
    int     reach, len;
    bit     jump;
    case ($urandom_range(0, 3))
      0: reach = 1;
      1: reach = 8;
      2: reach = 300;
      default: reach = 20000;
    endcase
    case ($urandom_range(0, 9))
      0: len = 1;
      1: len = 2;
      default: len = $urandom_range(3, 12);
    endcase
    p = '{rand_coord(), rand_coord(), rand_coord()};
    step = '{rand_delta(reach), rand_delta(reach), rand_delta(reach)};
    for (int i = 0; i < len; i++) begin
      jump = 1'b0;
      if (i > 0) begin
        case ($urandom_range(0, 9))
          0: step = '0;
          1, 2: ;
          3: step = '{-step.x, -step.y, -step.z};
          4: step = '{step.x <<< 1, step.y <<< 1, step.z <<< 1};
          5: begin
            p = '{rand_coord(), rand_coord(), rand_coord()};
            jump = 1'b1;
          end
          default: step = '{rand_delta(reach), rand_delta(reach), rand_delta(reach)};
        endcase
        if (!jump) p = '{p.x + step.x, p.y + step.y, p.z + step.z};
      end
      add_pending(p, i == len - 1, $urandom_range(0, 40) == 0);
    end
    return len;
  endfunction

  task automatic write_threshold(cos_t value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {IDX_COS_THRESHOLD, 2'b00};
    pwdata  <= APB_DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cos_thr = value;
  endtask

  task automatic wait_for_drain();
    wait (pending_points.size() == 0 && !points.valid && kept_expected.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // point sender
  int          send_wait;
  int          send_burst;
  point_word_t in_flight;

  always @(posedge clk) begin
    if (rst) begin
      points.valid <= 1'b0;
      send_wait = 0;
      send_burst = 0;
    end else begin
      if (points.valid && points.ready) filter_point(in_flight);
      if (!points.valid || points.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          points.valid <= 1'b0;
        end else if (pending_points.size() > 0 &&
                     !(pending_points[0].drain_first && kept_expected.size() > 0)) begin
          in_flight = pending_points.pop_front();
          points.point_x      <= in_flight.pt.x;
          points.point_y      <= in_flight.pt.y;
          points.point_z      <= in_flight.pt.z;
          points.end_of_curve <= in_flight.last;
          points.valid        <= 1'b1;
          send_wait = pick_wait(send_burst);
        end else begin
          points.valid <= 1'b0;
        end
      end
    end
  end

  // kept point receiver and checker
  int recv_wait;
  int recv_burst;

  always @(posedge clk) begin
    kept_word_t want;
    if (rst) begin
      kept.ready <= 1'b0;
      recv_wait = 0;
      recv_burst = 0;
    end else begin
      if (kept.valid && kept.ready) begin
        if (kept_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected kept word (%0d,%0d,%0d) done=%0b",
                                    kept.kept_x, kept.kept_y, kept.kept_z, kept.curve_done));
        end else begin
          want = kept_expected.pop_front();
          check_field("kept_x", kept.kept_x, want.pt.x);
          check_field("kept_y", kept.kept_y, want.pt.y);
          check_field("kept_z", kept.kept_z, want.pt.z);
          check_field("curve_done", CB'(kept.curve_done), CB'(want.done));
        end
        recv_wait = pick_wait(recv_burst);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        kept.ready <= 1'b0;
      end else begin
        kept.ready <= 1'b1;
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    cos_t thr_plan [NUM_PHASES];
    int   queued;
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    points.valid        = 1'b0;
    points.point_x      = '0;
    points.point_y      = '0;
    points.point_z      = '0;
    points.end_of_curve = 1'b0;
    kept.ready          = 1'b0;
    prev_pt             = '0;
    older_pt            = '0;
    pts_in_curve        = 0;
    cos_thr             = COS_RESET;
    thr_plan = '{COS_MIN, COS_RESET, cos_t'(0), cos_t'(23170), cos_t'(-16384),
                 cos_t'($urandom), cos_t'($urandom)};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed curves at the reset threshold
    push_point(COORD_MIN, COORD_MAX, 0, 1'b1);
    push_point(COORD_MAX, COORD_MIN, COORD_MIN, 1'b0);
    push_point(COORD_MIN, COORD_MAX, COORD_MAX, 1'b1);
    // straight run, right-angle turn, then a repeated point on both sides
    push_point(0, 0, 0, 1'b0);
    push_point(10, 0, 0, 1'b0);
    push_point(20, 0, 0, 1'b0);
    push_point(20, 10, 0, 1'b0);
    push_point(20, 10, 0, 1'b0);
    push_point(0, 10, 0, 1'b1);
    // full reversal across the whole coordinate range
    push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    // mixed extremes ending on a zero-length segment
    push_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    push_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
    push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    push_point(-1, 0, 1, 1'b0);
    push_point(-1, 0, 1, 1'b1);
    wait_for_drain();

    for (int k = 0; k < NUM_PHASES; k++) begin
      write_threshold(thr_plan[k]);
      queued = 0;
      while (queued < PHASE_ITEMS) queued += queue_curve();
      wait_for_drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### polyline_collinear_point_filter_unit.f
rtl/pcpf_pkg.sv
rtl/pcpf_if.sv
rtl/pcpf_regs.sv
rtl/pcpf_ctrl.sv
rtl/pcpf_dp.sv
rtl/polyline_collinear_point_filter_unit.sv
tb/polyline_collinear_point_filter_unit_test.sv
